### src/ffba_pkg.sv
package ffba_pkg;

  localparam int POOL_UNITS = 1024;
  localparam int MAP_W = 16;
  localparam int HALF_W = MAP_W / 2;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_REALLOC = 2'd1;
  localparam logic [1:0] OP_FREE    = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOMEM   = 2'd1;
  localparam logic [1:0] STAT_INVALID = 2'd2;
  localparam logic [1:0] STAT_FULL    = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FIND,
    S_DECIDE,
    S_FIT_RD,
    S_FIT_LO,
    S_FIT_HI,
    S_RNG_RD,
    S_RNG_OP,
    S_TBL_WR
  } state_t;

  typedef enum logic [1:0] {
    RM_CHECK,
    RM_SET,
    RM_CLEAR
  } rng_mode_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [9:0]  block_offset;
    logic [10:0] cur_length;
    logic [10:0] req_length;
  } ffba_cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  out_offset;
    logic [31:0] out_address;
    logic [10:0] out_length;
    logic        moved;
  } ffba_res_t;

endpackage

### src/first_fit_bitmap_allocator.sv
// First-fit allocator over a pool of POOL_UNITS units. Occupancy lives in a
// bitmap memory of 16-unit words, live blocks in a table memory of
// MAX_BLOCKS entries. After reset a clearing pass zeroes both memories;
// busy is high meanwhile. An item runs a search of the whole table, then,
// where needed, a first-fit scan of the bitmap words and a read-modify-write
// of each word of every range that it marks, checks or clears. busy stays
// high until the result: one item at a time. The result is shown for one
// cycle with done and cannot be stalled.
module first_fit_bitmap_allocator #(
  parameter int MAX_BLOCKS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  ffba_pkg::ffba_cmd_t  cmd,
  output logic                 done,
  output ffba_pkg::ffba_res_t  result,
  input  logic                 cfg_we,
  input  logic [31:0]          cfg_wdata
);

  localparam int POOL_UNITS = ffba_pkg::POOL_UNITS;
  localparam int MW = ffba_pkg::MAP_W;
  localparam int HW = ffba_pkg::HALF_W;
  localparam int WORDS = (POOL_UNITS + MW - 1) / MW;
  localparam int WAW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int TW = $clog2(MAX_BLOCKS);
  localparam int UW = (($clog2(POOL_UNITS + 1) > 11) ? $clog2(POOL_UNITS + 1) : 11) + 1;
  localparam int EW = 1 + 2 * UW;
  localparam int CLR_N = (WORDS > MAX_BLOCKS) ? WORDS : MAX_BLOCKS;
  localparam int CLW = $clog2(CLR_N);
  localparam logic [UW-1:0] POOL_U = UW'(POOL_UNITS);

  ffba_pkg::state_t state, state_next;
  ffba_pkg::rng_mode_t rmode, rmode_next;

  logic [CLW-1:0] ccnt, ccnt_next;
  logic [TW:0]    tcnt, tcnt_next;
  logic [1:0]     op_r, op_r_next;
  logic [UW-1:0]  off_r, off_r_next, cur_r, cur_r_next, req_r, req_r_next;
  logic           match_hit, match_hit_next, free_hit, free_hit_next;
  logic [TW-1:0]  match_idx, match_idx_next, free_idx, free_idx_next;
  logic [TW-1:0]  ent_idx, ent_idx_next;
  logic           ent_valid, ent_valid_next;
  logic [UW-1:0]  res_off, res_off_next, res_len, res_len_next;
  logic           res_moved, res_moved_next;
  logic [UW-1:0]  rlo, rlo_next, rhi, rhi_next;
  logic [WAW-1:0] rw, rw_next, fw, fw_next;
  logic [UW-1:0]  frun, frun_next, fs, fs_next;
  logic [31:0]    pool_base;

  logic           fin;
  logic [1:0]     fin_status;

  logic           bm_we, bm_re;
  logic [WAW-1:0] bm_waddr, bm_raddr;
  logic [MW-1:0]  bm_wdata, bm_rdata;
  logic           tb_we, tb_re;
  logic [TW-1:0]  tb_waddr, tb_raddr;
  logic [EW-1:0]  tb_wdata, tb_rdata;

  ffba_ram #(.DEPTH(WORDS), .WIDTH(MW)) u_map (
    .clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
    .re(bm_re), .raddr(bm_raddr), .rdata(bm_rdata)
  );

  ffba_ram #(.DEPTH(MAX_BLOCKS), .WIDTH(EW)) u_table (
    .clk(clk), .we(tb_we), .waddr(tb_waddr), .wdata(tb_wdata),
    .re(tb_re), .raddr(tb_raddr), .rdata(tb_rdata)
  );

  // decode helpers
  logic           e_valid;
  logic [UW-1:0]  e_start, e_len;
  logic [TW:0]    tcnt_m1;
  logic           eff_alloc, bad_req;
  logic [UW-1:0]  off_req, off_cur;
  logic [UW-1:0]  wbase_r, wbase_f, rhi_m1;
  logic [WAW-1:0] rlast;
  logic [MW-1:0]  rmask;

  assign e_valid = tb_rdata[EW-1];
  assign e_start = tb_rdata[2*UW-1:UW];
  assign e_len   = tb_rdata[UW-1:0];
  assign tcnt_m1 = tcnt - 1'b1;
  assign eff_alloc = (op_r == ffba_pkg::OP_ALLOC) ||
                     ((op_r == ffba_pkg::OP_REALLOC) && (cur_r == '0));
  assign bad_req = (req_r == '0) || (req_r > POOL_U);
  assign off_req = off_r + req_r;
  assign off_cur = off_r + cur_r;
  assign wbase_r = UW'({rw, 4'b0000});
  assign wbase_f = UW'({fw, 4'b0000});
  assign rhi_m1  = rhi - 1'b1;
  assign rlast   = rhi_m1[WAW+3:4];

  always_comb begin
    for (int i = 0; i < MW; i++) begin
      rmask[i] = ((wbase_r + UW'(i)) >= rlo) && ((wbase_r + UW'(i)) < rhi);
    end
  end

  // first-fit over one half word, run carried across halves and words
  logic [HW-1:0] fit_data;
  logic [UW-1:0] fit_base, fit_run, fit_s, fit_start, fit_u;
  logic          fit_found, fit_occ;

  always_comb begin
    fit_data  = (state == ffba_pkg::S_FIT_HI) ? bm_rdata[MW-1:HW] : bm_rdata[HW-1:0];
    fit_base  = (state == ffba_pkg::S_FIT_HI) ? wbase_f + UW'(HW) : wbase_f;
    fit_run   = frun;
    fit_s     = fs;
    fit_found = 1'b0;
    fit_start = '0;
    fit_u     = '0;
    fit_occ   = 1'b0;
    for (int i = 0; i < HW; i++) begin
      fit_u   = fit_base + UW'(i);
      fit_occ = fit_data[i] || (fit_u >= POOL_U);
      if (!fit_found) begin
        if (fit_occ) begin
          fit_run = '0;
          fit_s   = fit_u + 1'b1;
        end else begin
          fit_run = fit_run + 1'b1;
        end
        if (fit_run == req_r) begin
          fit_found = 1'b1;
          fit_start = fit_s;
        end
      end
    end
  end

  always_comb begin
    state_next = state;      rmode_next = rmode;
    ccnt_next = ccnt;        tcnt_next = tcnt;
    op_r_next = op_r;        off_r_next = off_r;
    cur_r_next = cur_r;      req_r_next = req_r;
    match_hit_next = match_hit;  match_idx_next = match_idx;
    free_hit_next = free_hit;    free_idx_next = free_idx;
    ent_idx_next = ent_idx;  ent_valid_next = ent_valid;
    res_off_next = res_off;  res_len_next = res_len;
    res_moved_next = res_moved;
    rlo_next = rlo;          rhi_next = rhi;
    rw_next = rw;            fw_next = fw;
    frun_next = frun;        fs_next = fs;
    fin = 1'b0;              fin_status = ffba_pkg::STAT_OK;
    bm_we = 1'b0;  bm_waddr = '0;  bm_wdata = '0;
    bm_re = 1'b0;  bm_raddr = '0;
    tb_we = 1'b0;  tb_waddr = '0;  tb_wdata = '0;
    tb_re = 1'b0;  tb_raddr = '0;

    unique case (state)
      ffba_pkg::S_CLEAR: begin
        bm_we    = ({1'b0, ccnt} < (CLW+1)'(WORDS));
        bm_waddr = ccnt[WAW-1:0];
        tb_we    = ({1'b0, ccnt} < (CLW+1)'(MAX_BLOCKS));
        tb_waddr = ccnt[TW-1:0];
        if (ccnt == CLW'(CLR_N - 1)) begin
          state_next = ffba_pkg::S_IDLE;
        end else begin
          ccnt_next = ccnt + 1'b1;
        end
      end

      ffba_pkg::S_IDLE: begin
        if (start) begin
          op_r_next      = cmd.op;
          off_r_next     = UW'(cmd.block_offset);
          cur_r_next     = UW'(cmd.cur_length);
          req_r_next     = UW'(cmd.req_length);
          match_hit_next = 1'b0;
          free_hit_next  = 1'b0;
          res_moved_next = 1'b0;
          tcnt_next      = '0;
          state_next     = ffba_pkg::S_FIND;
        end
      end

      // table search, one entry a cycle, each entry checked from the registered read data
      ffba_pkg::S_FIND: begin
        if (tcnt < (TW+1)'(MAX_BLOCKS)) begin
          tb_re    = 1'b1;
          tb_raddr = tcnt[TW-1:0];
        end
        if (tcnt != '0) begin
          if (e_valid && e_start == off_r && e_len == cur_r && !match_hit) begin
            match_hit_next = 1'b1;
            match_idx_next = tcnt_m1[TW-1:0];
          end
          if (!e_valid && !free_hit) begin
            free_hit_next = 1'b1;
            free_idx_next = tcnt_m1[TW-1:0];
          end
        end
        if (tcnt == (TW+1)'(MAX_BLOCKS)) begin
          state_next = ffba_pkg::S_DECIDE;
        end else begin
          tcnt_next = tcnt + 1'b1;
        end
      end

      ffba_pkg::S_DECIDE: begin
        if (eff_alloc) begin
          if (bad_req) begin
            fin = 1'b1;  fin_status = ffba_pkg::STAT_NOMEM;
          end else if (!free_hit) begin
            fin = 1'b1;  fin_status = ffba_pkg::STAT_FULL;
          end else begin
            ent_idx_next = free_idx;  ent_valid_next = 1'b1;
            fw_next = '0;  frun_next = '0;  fs_next = '0;
            state_next = ffba_pkg::S_FIT_RD;
          end
        end else if (op_r == ffba_pkg::OP_FREE) begin
          if (!match_hit) begin
            fin = 1'b1;  fin_status = ffba_pkg::STAT_INVALID;
          end else begin
            ent_idx_next = match_idx;  ent_valid_next = 1'b0;
            res_off_next = '0;  res_len_next = '0;
            rlo_next = off_r;  rhi_next = off_cur;  rw_next = off_r[WAW+3:4];
            rmode_next = ffba_pkg::RM_CLEAR;
            state_next = ffba_pkg::S_RNG_RD;
          end
        end else if (op_r == ffba_pkg::OP_REALLOC) begin
          if (!match_hit) begin
            fin = 1'b1;  fin_status = ffba_pkg::STAT_INVALID;
          end else if (req_r == '0) begin
            fin = 1'b1;  fin_status = ffba_pkg::STAT_NOMEM;
          end else begin
            ent_idx_next = match_idx;  ent_valid_next = 1'b1;
            res_off_next = off_r;  res_len_next = req_r;
            if (req_r == cur_r) begin
              state_next = ffba_pkg::S_TBL_WR;
            end else if (req_r < cur_r) begin
              rlo_next = off_req;  rhi_next = off_cur;  rw_next = off_req[WAW+3:4];
              rmode_next = ffba_pkg::RM_CLEAR;
              state_next = ffba_pkg::S_RNG_RD;
            end else if (off_req > POOL_U) begin
              fw_next = '0;  frun_next = '0;  fs_next = '0;
              state_next = ffba_pkg::S_FIT_RD;
            end else begin
              rlo_next = off_cur;  rhi_next = off_req;  rw_next = off_cur[WAW+3:4];
              rmode_next = ffba_pkg::RM_CHECK;
              state_next = ffba_pkg::S_RNG_RD;
            end
          end
        end else begin
          fin = 1'b1;  fin_status = ffba_pkg::STAT_NOMEM;
        end
      end

      ffba_pkg::S_FIT_RD: begin
        bm_re      = 1'b1;
        bm_raddr   = fw;
        state_next = ffba_pkg::S_FIT_LO;
      end

      ffba_pkg::S_FIT_LO, ffba_pkg::S_FIT_HI: begin
        frun_next = fit_run;
        fs_next   = fit_s;
        if (fit_found) begin
          res_off_next   = fit_start;
          res_len_next   = req_r;
          res_moved_next = !eff_alloc;
          rlo_next = fit_start;  rhi_next = fit_start + req_r;
          rw_next  = fit_start[WAW+3:4];
          rmode_next = ffba_pkg::RM_SET;
          state_next = ffba_pkg::S_RNG_RD;
        end else if (state == ffba_pkg::S_FIT_LO) begin
          state_next = ffba_pkg::S_FIT_HI;
        end else if (fw == WAW'(WORDS - 1)) begin
          fin = 1'b1;  fin_status = ffba_pkg::STAT_NOMEM;
        end else begin
          fw_next    = fw + 1'b1;
          bm_re      = 1'b1;
          bm_raddr   = fw + 1'b1;
          state_next = ffba_pkg::S_FIT_LO;
        end
      end

      ffba_pkg::S_RNG_RD: begin
        bm_re      = 1'b1;
        bm_raddr   = rw;
        state_next = ffba_pkg::S_RNG_OP;
      end

      // read-modify-write of one bitmap word; in check mode the word is only tested
      ffba_pkg::S_RNG_OP: begin
        if (rmode == ffba_pkg::RM_CHECK) begin
          if ((bm_rdata & rmask) != '0) begin
            // no room behind the block: relocate
            fw_next = '0;  frun_next = '0;  fs_next = '0;
            state_next = ffba_pkg::S_FIT_RD;
          end else if (rw == rlast) begin
            rw_next    = rlo[WAW+3:4];
            rmode_next = ffba_pkg::RM_SET;
            state_next = ffba_pkg::S_RNG_RD;
          end else begin
            rw_next    = rw + 1'b1;
            state_next = ffba_pkg::S_RNG_RD;
          end
        end else begin
          bm_we    = 1'b1;
          bm_waddr = rw;
          bm_wdata = (rmode == ffba_pkg::RM_SET) ? (bm_rdata | rmask) : (bm_rdata & ~rmask);
          if (rw != rlast) begin
            rw_next    = rw + 1'b1;
            state_next = ffba_pkg::S_RNG_RD;
          end else if (rmode == ffba_pkg::RM_SET && res_moved) begin
            // new run marked, now release the old block
            rlo_next = off_r;  rhi_next = off_cur;  rw_next = off_r[WAW+3:4];
            rmode_next = ffba_pkg::RM_CLEAR;
            state_next = ffba_pkg::S_RNG_RD;
          end else begin
            state_next = ffba_pkg::S_TBL_WR;
          end
        end
      end

      ffba_pkg::S_TBL_WR: begin
        tb_we    = 1'b1;
        tb_waddr = ent_idx;
        tb_wdata = {ent_valid, res_off, res_len};
        fin      = 1'b1;
      end

      default: state_next = ffba_pkg::S_CLEAR;
    endcase

    if (fin) begin
      state_next = ffba_pkg::S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ffba_pkg::S_CLEAR;
      ccnt      <= '0;
      done      <= 1'b0;
      pool_base <= '0;
    end else begin
      state <= state_next;
      ccnt  <= ccnt_next;
      done  <= fin;
      if (cfg_we) begin
        pool_base <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    rmode     <= rmode_next;
    tcnt      <= tcnt_next;
    op_r      <= op_r_next;
    off_r     <= off_r_next;
    cur_r     <= cur_r_next;
    req_r     <= req_r_next;
    match_hit <= match_hit_next;
    match_idx <= match_idx_next;
    free_hit  <= free_hit_next;
    free_idx  <= free_idx_next;
    ent_idx   <= ent_idx_next;
    ent_valid <= ent_valid_next;
    res_off   <= res_off_next;
    res_len   <= res_len_next;
    res_moved <= res_moved_next;
    rlo       <= rlo_next;
    rhi       <= rhi_next;
    rw        <= rw_next;
    fw        <= fw_next;
    frun      <= frun_next;
    fs        <= fs_next;
    if (fin) begin
      result.status <= fin_status;
      if (fin_status == ffba_pkg::STAT_OK) begin
        result.out_offset  <= res_off[9:0];
        result.out_length  <= res_len[10:0];
        result.moved       <= res_moved;
        result.out_address <= (res_len != '0) ? pool_base + 32'(res_off) : 32'd0;
      end else begin
        result.out_offset  <= '0;
        result.out_length  <= '0;
        result.moved       <= 1'b0;
        result.out_address <= '0;
      end
    end
  end

  assign busy = (state != ffba_pkg::S_IDLE);

  a_one_beat: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_moved_ok: assert property (@(posedge clk) disable iff (rst)
    (done && result.moved) |-> (result.status == ffba_pkg::STAT_OK))
    else $error("moved flag on a failed request");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ffba_pkg::STAT_OK) |->
      (result.out_length == '0 && result.out_address == '0))
    else $error("error result carries a block");

endmodule

### src/ffba_ram.sv
module ffba_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### tb/sv/tb_first_fit_bitmap_allocator.sv
`timescale 1ns / 100ps

module tb_first_fit_bitmap_allocator;

  localparam int UNITS = 1024;
  localparam int BLOCKS = 64;
  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  ffba_pkg::ffba_cmd_t cmd = '0;
  logic done;
  ffba_pkg::ffba_res_t result;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  int idle_pct = 0;
  int quiet_cycles = 0;

  always #2 clk = ~clk;

  first_fit_bitmap_allocator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  class alloc_scoreboard;
    bit map [UNITS];
    bit live [BLOCKS];
    logic [9:0] blk_start [BLOCKS];
    logic [10:0] blk_len [BLOCKS];
    logic [31:0] base;
    ffba_pkg::ffba_res_t pending [$];
    int errors;

    function new();
      base = 0;
      errors = 0;
    endfunction

    function void mark(int from, int count, bit used);
      for (int k = 0; k < count; k++)
        if (from + k < UNITS) map[from + k] = used;
    endfunction

    function int fit(int n);
      int run;
      int s;
      run = 0;
      s = 0;
      if (n == 0 || n > UNITS) return -1;
      for (int i = 0; i < UNITS; i++) begin
        if (map[i]) begin
          run = 0;
          s = i + 1;
        end else run++;
        if (run == n) return s;
      end
      return -1;
    endfunction

    function int find(int s, int len);
      for (int e = 0; e < BLOCKS; e++)
        if (live[e] && blk_start[e] == s && blk_len[e] == len) return e;
      return -1;
    endfunction

    function ffba_pkg::ffba_res_t mk(logic [1:0] st, int off, int len, bit mv);
      ffba_pkg::ffba_res_t r;
      r = '0;
      r.status = st;
      if (st == ffba_pkg::STAT_OK) begin
        r.out_offset = off[9:0];
        r.out_length = len[10:0];
        r.out_address = (len != 0) ? base + 32'(off) : 32'd0;
        r.moved = mv;
      end
      return r;
    endfunction

    function ffba_pkg::ffba_res_t do_alloc(int req);
      int e;
      int s;
      if (req == 0 || req > UNITS) return mk(ffba_pkg::STAT_NOMEM, 0, 0, 0);
      e = -1;
      for (int i = BLOCKS - 1; i >= 0; i--) if (!live[i]) e = i;
      if (e < 0) return mk(ffba_pkg::STAT_FULL, 0, 0, 0);
      s = fit(req);
      if (s < 0) return mk(ffba_pkg::STAT_NOMEM, 0, 0, 0);
      mark(s, req, 1);
      live[e] = 1;
      blk_start[e] = s[9:0];
      blk_len[e] = req[10:0];
      return mk(ffba_pkg::STAT_OK, s, req, 0);
    endfunction

    function void note_cmd(ffba_pkg::ffba_cmd_t c);
      int off;
      int cur;
      int req;
      int e;
      int s;
      bit room;
      ffba_pkg::ffba_res_t r;
      off = c.block_offset;
      cur = c.cur_length;
      req = c.req_length;
      if (c.op == ffba_pkg::OP_ALLOC) r = do_alloc(req);
      else if (c.op == ffba_pkg::OP_FREE) begin
        e = find(off, cur);
        if (e < 0) r = mk(ffba_pkg::STAT_INVALID, 0, 0, 0);
        else begin
          mark(off, cur, 0);
          live[e] = 0;
          r = mk(ffba_pkg::STAT_OK, 0, 0, 0);
        end
      end else if (c.op == ffba_pkg::OP_REALLOC) begin
        e = find(off, cur);
        if (cur == 0) r = do_alloc(req);
        else if (e < 0) r = mk(ffba_pkg::STAT_INVALID, 0, 0, 0);
        else if (req == 0) r = mk(ffba_pkg::STAT_NOMEM, 0, 0, 0);
        else if (req <= cur) begin
          mark(off + req, cur - req, 0);
          blk_len[e] = req[10:0];
          r = mk(ffba_pkg::STAT_OK, off, req, 0);
        end else begin
          room = off + req <= UNITS;
          for (int k = cur; room && k < req; k++) if (map[off + k]) room = 0;
          if (room) begin
            mark(off + cur, req - cur, 1);
            blk_len[e] = req[10:0];
            r = mk(ffba_pkg::STAT_OK, off, req, 0);
          end else begin
            s = fit(req);
            if (s < 0) r = mk(ffba_pkg::STAT_NOMEM, 0, 0, 0);
            else begin
              mark(s, req, 1);
              mark(off, cur, 0);
              blk_start[e] = s[9:0];
              blk_len[e] = req[10:0];
              r = mk(ffba_pkg::STAT_OK, s, req, 1);
            end
          end
        end
      end else r = mk(ffba_pkg::STAT_NOMEM, 0, 0, 0);
      pending = {pending, r};
    endfunction

    function void check_result(ffba_pkg::ffba_res_t got);
      ffba_pkg::ffba_res_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.out_offset !== want.out_offset ||
          got.out_address !== want.out_address || got.out_length !== want.out_length ||
          got.moved !== want.moved) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: exp st=%0d off=%0d addr=%h len=%0d mv=%0d",
                   want.status, want.out_offset, want.out_address, want.out_length,
                   want.moved);
          $display("          got st=%0d off=%0d addr=%h len=%0d mv=%0d",
                   got.status, got.out_offset, got.out_address, got.out_length,
                   got.moved);
        end
      end
    endfunction

    // pick a live block for well-formed frees and reallocs
    function bit pick_live(output int s, output int len);
      int idx [$];
      int e;
      for (int i = 0; i < BLOCKS; i++) if (live[i]) idx = {idx, i};
      if (idx.size() == 0) return 0;
      e = idx[$urandom_range(idx.size() - 1)];
      s = blk_start[e];
      len = blk_len[e];
      return 1;
    endfunction

    function int live_count();
      int n;
      n = 0;
      for (int i = 0; i < BLOCKS; i++) n += live[i];
      return n;
    endfunction
  endclass

  alloc_scoreboard sb = new();

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
    if (!rst && ((start && !busy) || done)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("tb_first_fit_bitmap_allocator: errors");
      $finish;
    end
  end

  task automatic send_cmd(logic [1:0] op, int off, int cur, int req);
    ffba_pkg::ffba_cmd_t c;
    c.op = op;
    c.block_offset = off[9:0];
    c.cur_length = cur[10:0];
    c.req_length = req[10:0];
    @(posedge clk);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_cmd(c);
    start <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_base(logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.base = v;
  endtask

  function automatic int rnd_len();
    case ($urandom_range(9))
      0: return $urandom_range(2047);
      1: return $urandom_range(1024, 300);
      default: return $urandom_range(40, 1);
    endcase
  endfunction

  task automatic random_cmd();
    int s;
    int len;
    int r;
    r = $urandom_range(99);
    if (r < 40) begin
      send_cmd(ffba_pkg::OP_ALLOC, $urandom_range(1023), $urandom_range(2047), rnd_len());
    end else if (r < 65 && sb.pick_live(s, len)) begin
      send_cmd(ffba_pkg::OP_FREE, s, len, $urandom_range(2047));
    end else if (r < 88 && sb.pick_live(s, len)) begin
      send_cmd(ffba_pkg::OP_REALLOC, s, len, ($urandom_range(3) == 0) ? 0 : rnd_len());
    end else if (r < 92) begin
      send_cmd(ffba_pkg::OP_REALLOC, $urandom_range(1023), 0, rnd_len());
    end else begin
      send_cmd(2'($urandom_range(3)), $urandom_range(1023), $urandom_range(2047),
               $urandom_range(2047));
    end
  endtask

  initial begin
    int s;
    int len;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_base(32'hFFFF_FFF0);
    // directed beats
    send_cmd(ffba_pkg::OP_ALLOC, 0, 0, 0);
    send_cmd(ffba_pkg::OP_ALLOC, 0, 0, 1025);
    send_cmd(ffba_pkg::OP_ALLOC, 1023, 2047, 2047);
    send_cmd(ffba_pkg::OP_ALLOC, 0, 0, 1024);
    send_cmd(ffba_pkg::OP_ALLOC, 0, 0, 1);
    send_cmd(ffba_pkg::OP_FREE, 0, 1024, 0);
    send_cmd(ffba_pkg::OP_ALLOC, 0, 0, 16);
    send_cmd(ffba_pkg::OP_ALLOC, 0, 0, 16);
    send_cmd(ffba_pkg::OP_REALLOC, 0, 16, 16);
    send_cmd(ffba_pkg::OP_REALLOC, 0, 16, 0);
    send_cmd(ffba_pkg::OP_REALLOC, 0, 16, 8);
    send_cmd(ffba_pkg::OP_REALLOC, 0, 8, 12);
    send_cmd(ffba_pkg::OP_REALLOC, 0, 12, 40);
    send_cmd(ffba_pkg::OP_REALLOC, 16, 16, 1010);
    send_cmd(ffba_pkg::OP_REALLOC, 5, 7, 9);
    send_cmd(ffba_pkg::OP_FREE, 5, 7, 0);
    send_cmd(ffba_pkg::OP_REALLOC, 0, 0, 3);
    send_cmd(2'd3, 1023, 2047, 2047);
    send_cmd(ffba_pkg::OP_REALLOC, 1000, 0, 24);
    drain();
    while (sb.pick_live(s, len)) send_cmd(ffba_pkg::OP_FREE, s, len, 0);
    // fill the table to hit table full
    for (int i = 0; i < BLOCKS + 2; i++) send_cmd(ffba_pkg::OP_ALLOC, 0, 0, 1);
    send_cmd(ffba_pkg::OP_REALLOC, 0, 0, 1);
    drain();
    while (sb.pick_live(s, len)) send_cmd(ffba_pkg::OP_FREE, s, len, 0);
    drain();
    write_base(32'h0000_0000);
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: idle_pct = 0;
        1: idle_pct = 73;
        2: idle_pct = 9;
        default: idle_pct = 0;
      endcase
      for (int i = 0; i < 70; i++) random_cmd();
      drain();
      write_base($urandom());
    end
    write_base(32'hFFFF_FFFF);
    for (int i = 0; i < 10; i++) random_cmd();
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_first_fit_bitmap_allocator: clean");
    else
      $display("tb_first_fit_bitmap_allocator: errors");
    $finish;
  end

endmodule

### first_fit_bitmap_allocator.f
src/ffba_pkg.sv
src/ffba_ram.sv
src/first_fit_bitmap_allocator.sv
tb/sv/tb_first_fit_bitmap_allocator.sv
